// ----- sv/crnav_pkg.sv -----
package crnav_pkg;

	localparam int unsigned CNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] STRAIGHT_RUN = 16'd5;

	localparam logic [CNT_W-1:0] LINEAR_LIMIT_RST = 16'd1000;
	localparam logic [CNT_W-1:0] CIRCLE_LIMIT_RST = 16'd1000;
	localparam logic [CNT_W-1:0] EDGE_LIMIT_RST = 16'd1000;
	localparam logic [CNT_W-1:0] EDGE_CLEAR_LIMIT_RST = 16'd200;

	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_CLEAR_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_CIRCLE = 2'd1,
		MODE_EDGE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CMD_STOP = 3'd0,
		CMD_STRAIGHT = 3'd1,
		CMD_BACK_RIGHT_FAST = 3'd2,
		CMD_FWD_RIGHT_SLOW = 3'd3,
		CMD_ROTATE_LEFT = 3'd4,
		CMD_SPIRAL = 3'd5,
		CMD_NONE = 3'd6
	} cmd_t;

	typedef struct packed {
		logic front_blocked;
		logic left_blocked;
		logic right_blocked;
		logic dust_full;
	} sens_t;

	typedef struct packed {
		logic vacuum_on;
		cmd_t move_cmd;
		logic [CNT_W-1:0] spiral_amount;
		mode_t mode_now;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0] linear_limit;
		logic [CNT_W-1:0] circle_limit;
		logic [CNT_W-1:0] edge_limit;
		logic [CNT_W-1:0] edge_clear_limit;
	} limits_t;

endpackage

// ----- sv/crnav_if.sv -----
interface crnav_sens_if;
	logic valid;
	logic ready;
	logic front_blocked;
	logic left_blocked;
	logic right_blocked;
	logic dust_full;

	modport source (output valid, output front_blocked, output left_blocked,
		output right_blocked, output dust_full, input ready);
	modport sink (input valid, input front_blocked, input left_blocked,
		input right_blocked, input dust_full, output ready);
endinterface

interface crnav_res_if;
	logic valid;
	logic ready;
	logic vacuum_on;
	logic [2:0] move_cmd;
	logic [15:0] spiral_amount;
	logic [1:0] mode_now;

	modport source (output valid, output vacuum_on, output move_cmd,
		output spiral_amount, output mode_now, input ready);
	modport sink (input valid, input vacuum_on, input move_cmd,
		input spiral_amount, input mode_now, output ready);
endinterface

interface crnav_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/crnav_cfg.sv -----
module crnav_cfg (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [crnav_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [crnav_pkg::CNT_W-1:0] wr_data,
	output crnav_pkg::limits_t limits
);

	crnav_pkg::limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.linear_limit <= crnav_pkg::LINEAR_LIMIT_RST;
			limits_q.circle_limit <= crnav_pkg::CIRCLE_LIMIT_RST;
			limits_q.edge_limit <= crnav_pkg::EDGE_LIMIT_RST;
			limits_q.edge_clear_limit <= crnav_pkg::EDGE_CLEAR_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				crnav_pkg::REG_LINEAR_LIMIT: limits_q.linear_limit <= wr_data;
				crnav_pkg::REG_CIRCLE_LIMIT: limits_q.circle_limit <= wr_data;
				crnav_pkg::REG_EDGE_LIMIT: limits_q.edge_limit <= wr_data;
				crnav_pkg::REG_EDGE_CLEAR_LIMIT: limits_q.edge_clear_limit <= wr_data;
				default: ;
			endcase
		end
	end

	assign limits = limits_q;

endmodule

// ----- sv/crnav_nav.sv -----
module crnav_nav (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input crnav_pkg::sens_t sens,
	input crnav_pkg::limits_t limits,
	output crnav_pkg::res_t res
);

	crnav_pkg::mode_t mode_q, mode_d;
	logic [crnav_pkg::CNT_W-1:0] mode_ticks_q, mode_ticks_d;
	logic [crnav_pkg::CNT_W-1:0] clear_ticks_q, clear_ticks_d;
	logic [crnav_pkg::CNT_W-1:0] straight_ticks_q, straight_ticks_d;

	logic stop;
	logic [crnav_pkg::CNT_W-1:0] mt_inc, ct_inc, st_inc;
	logic lin_to, circ_to, edge_to, clear_to;

	function automatic logic [crnav_pkg::CNT_W-1:0] sat_inc(
		input logic [crnav_pkg::CNT_W-1:0] v
	);
		return (v == crnav_pkg::CNT_MAX) ? v : v + 1'b1;
	endfunction

	assign stop = sens.dust_full | (sens.left_blocked & sens.right_blocked);
	assign mt_inc = sat_inc(mode_ticks_q);
	assign ct_inc = sat_inc(clear_ticks_q);
	assign st_inc = sat_inc(straight_ticks_q);
	assign lin_to = mt_inc > limits.linear_limit;
	assign circ_to = mt_inc > limits.circle_limit;
	assign edge_to = mt_inc > limits.edge_limit;
	assign clear_to = ct_inc > limits.edge_clear_limit;

	// next state
	always_comb begin
		mode_d = mode_q;
		mode_ticks_d = mode_ticks_q;
		clear_ticks_d = clear_ticks_q;
		straight_ticks_d = straight_ticks_q;
		if (!stop) begin
			unique case (mode_q)
				crnav_pkg::MODE_CIRCLE: begin
					if (sens.front_blocked) begin
						mode_d = crnav_pkg::MODE_EDGE;
						mode_ticks_d = '0;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else if (circ_to) begin
						mode_ticks_d = '0;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else begin
						mode_ticks_d = mt_inc;
					end
				end
				crnav_pkg::MODE_EDGE: begin
					if (sens.front_blocked) begin
						mode_ticks_d = mt_inc;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else if (edge_to) begin
						mode_d = crnav_pkg::MODE_LINEAR;
						mode_ticks_d = '0;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else if (clear_to) begin
						mode_d = crnav_pkg::MODE_CIRCLE;
						mode_ticks_d = '0;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else begin
						mode_ticks_d = mt_inc;
						clear_ticks_d = ct_inc;
						straight_ticks_d = st_inc;
					end
				end
				default: begin
					mode_d = crnav_pkg::MODE_LINEAR;
					if (!sens.front_blocked && lin_to) begin
						mode_d = crnav_pkg::MODE_CIRCLE;
						mode_ticks_d = '0;
						clear_ticks_d = '0;
						straight_ticks_d = '0;
					end else begin
						mode_ticks_d = mt_inc;
					end
				end
			endcase
		end
	end

	// result
	always_comb begin
		res.vacuum_on = !stop;
		res.move_cmd = crnav_pkg::CMD_NONE;
		res.spiral_amount = '0;
		res.mode_now = mode_d;
		if (stop) begin
			res.move_cmd = crnav_pkg::CMD_STOP;
		end else begin
			unique case (mode_q)
				crnav_pkg::MODE_CIRCLE: begin
					if (!sens.front_blocked && !circ_to) begin
						res.move_cmd = crnav_pkg::CMD_SPIRAL;
						res.spiral_amount = mt_inc;
					end
				end
				crnav_pkg::MODE_EDGE: begin
					if (sens.front_blocked) begin
						res.move_cmd = crnav_pkg::CMD_BACK_RIGHT_FAST;
					end else if (edge_to) begin
						res.move_cmd = crnav_pkg::CMD_ROTATE_LEFT;
					end else if (!clear_to) begin
						res.move_cmd = (st_inc <= crnav_pkg::STRAIGHT_RUN) ?
							crnav_pkg::CMD_STRAIGHT : crnav_pkg::CMD_FWD_RIGHT_SLOW;
					end
				end
				default: begin
					if (sens.front_blocked) begin
						res.move_cmd = crnav_pkg::CMD_ROTATE_LEFT;
					end else if (!lin_to) begin
						res.move_cmd = crnav_pkg::CMD_STRAIGHT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= crnav_pkg::MODE_LINEAR;
			mode_ticks_q <= '0;
			clear_ticks_q <= '0;
			straight_ticks_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			mode_ticks_q <= mode_ticks_d;
			clear_ticks_q <= clear_ticks_d;
			straight_ticks_q <= straight_ticks_d;
		end
	end

endmodule

// ----- sv/cleaning_robot_navigation_fsm_top.sv -----
// Cleaning robot navigator. Each sensor beat yields exactly one result beat, in order.
// A beat is registered on entry, stepped through the mode and counter logic and held in
// an output register until taken; a new beat is accepted every cycle while the result
// side keeps up, and the single mode/counter state update per beat sets that rate.
// Limits are written through the cfg channel, indexed by the REG_*_LIMIT constants;
// the user must write them only while idle, the block does not check it.
module cleaning_robot_navigation_fsm_top (
	input logic clk,
	input logic arst_n,
	crnav_sens_if.sink sens,
	crnav_res_if.source res,
	crnav_cfg_if.sink cfg
);

	logic valid_s1;
	crnav_pkg::sens_t sens_s1;
	logic valid_s2;
	crnav_pkg::res_t res_s2;
	crnav_pkg::res_t step_res;
	crnav_pkg::limits_t limits;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || res.ready);
	assign sens.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	crnav_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg.valid),
		.wr_index(cfg.index),
		.wr_data(cfg.data),
		.limits(limits)
	);

	crnav_nav u_nav (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.sens(sens_s1),
		.limits(limits),
		.res(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sens.ready) begin
			valid_s1 <= sens.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sens.valid && sens.ready) begin
			sens_s1.front_blocked <= sens.front_blocked;
			sens_s1.left_blocked <= sens.left_blocked;
			sens_s1.right_blocked <= sens.right_blocked;
			sens_s1.dust_full <= sens.dust_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign res.valid = valid_s2;
	assign res.vacuum_on = res_s2.vacuum_on;
	assign res.move_cmd = res_s2.move_cmd;
	assign res.spiral_amount = res_s2.spiral_amount;
	assign res.mode_now = res_s2.mode_now;

endmodule

// ----- sv/crnav_chk.sv -----
module crnav_chk (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic res_vacuum_on,
	input logic [2:0] res_move_cmd,
	input logic [15:0] res_spiral_amount,
	input logic [1:0] res_mode_now
);

	// stop beat carries nothing else
	a_stop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_vacuum_on |->
			res_move_cmd == crnav_pkg::CMD_STOP && res_spiral_amount == '0)
		else $error("stop beat with movement or spiral");

	a_run_not_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_vacuum_on |-> res_move_cmd != crnav_pkg::CMD_STOP)
		else $error("stop command while vacuum on");

	// spiral only while circling, with a nonzero amount
	a_spiral_circle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_move_cmd == crnav_pkg::CMD_SPIRAL |->
			res_mode_now == crnav_pkg::MODE_CIRCLE && res_spiral_amount != '0)
		else $error("spiral outside circling");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_move_cmd)
			&& $stable(res_spiral_amount) && $stable(res_mode_now))
		else $error("result beat dropped or changed while stalled");

endmodule

bind cleaning_robot_navigation_fsm_top crnav_chk u_crnav_chk (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_vacuum_on(res.vacuum_on),
	.res_move_cmd(res.move_cmd),
	.res_spiral_amount(res.spiral_amount),
	.res_mode_now(res.mode_now)
);

// ----- bench/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [crnav_pkg::CNT_W-1:0] cnt_t;

	logic clk = 1'b0;
	logic arst_n;

	crnav_sens_if sens();
	crnav_res_if res();
	crnav_cfg_if cfg();

	cleaning_robot_navigation_fsm_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sens(sens),
		.res(res),
		.cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// navigator model state
	crnav_pkg::limits_t lim;
	crnav_pkg::mode_t nav_mode;
	cnt_t nav_ticks;
	cnt_t clear_ticks;
	cnt_t straight_ticks;

	crnav_pkg::res_t due_moves[$];
	int n_bad = 0;
	bit idle_on = 1'b1;
	int hold_left = 0;
	int stall_left = 0;

	function automatic cnt_t bump(cnt_t v);
		return (v == crnav_pkg::CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void restart_mode(crnav_pkg::mode_t m);
		nav_mode = m;
		nav_ticks = '0;
		clear_ticks = '0;
		straight_ticks = '0;
	endfunction

	function automatic crnav_pkg::res_t nav_step(crnav_pkg::sens_t s);
		crnav_pkg::res_t r;
		r.vacuum_on = 1'b1;
		r.move_cmd = crnav_pkg::CMD_NONE;
		r.spiral_amount = '0;
		if (s.dust_full || (s.left_blocked && s.right_blocked)) begin
			r.vacuum_on = 1'b0;
			r.move_cmd = crnav_pkg::CMD_STOP;
		end else begin
			case (nav_mode)
				crnav_pkg::MODE_CIRCLE: begin
					nav_ticks = bump(nav_ticks);
					if (s.front_blocked) begin
						restart_mode(crnav_pkg::MODE_EDGE);
					end else if (nav_ticks > lim.circle_limit) begin
						restart_mode(crnav_pkg::MODE_CIRCLE);
					end else begin
						r.move_cmd = crnav_pkg::CMD_SPIRAL;
						r.spiral_amount = nav_ticks;
					end
				end
				crnav_pkg::MODE_EDGE: begin
					nav_ticks = bump(nav_ticks);
					clear_ticks = bump(clear_ticks);
					if (s.front_blocked) begin
						clear_ticks = '0;
						straight_ticks = '0;
						r.move_cmd = crnav_pkg::CMD_BACK_RIGHT_FAST;
					end else if (nav_ticks > lim.edge_limit) begin
						r.move_cmd = crnav_pkg::CMD_ROTATE_LEFT;
						restart_mode(crnav_pkg::MODE_LINEAR);
					end else if (clear_ticks > lim.edge_clear_limit) begin
						restart_mode(crnav_pkg::MODE_CIRCLE);
					end else begin
						straight_ticks = bump(straight_ticks);
						if (straight_ticks <= crnav_pkg::STRAIGHT_RUN) begin
							r.move_cmd = crnav_pkg::CMD_STRAIGHT;
						end else begin
							r.move_cmd = crnav_pkg::CMD_FWD_RIGHT_SLOW;
						end
					end
				end
				default: begin
					nav_mode = crnav_pkg::MODE_LINEAR;
					nav_ticks = bump(nav_ticks);
					if (s.front_blocked) begin
						r.move_cmd = crnav_pkg::CMD_ROTATE_LEFT;
					end else if (nav_ticks > lim.linear_limit) begin
						restart_mode(crnav_pkg::MODE_CIRCLE);
					end else begin
						r.move_cmd = crnav_pkg::CMD_STRAIGHT;
					end
				end
			endcase
		end
		r.mode_now = nav_mode;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic cnt_t pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return '0;
		end
		if (r < 20) begin
			return crnav_pkg::CNT_MAX;
		end
		if (r < 30) begin
			return cnt_t'($urandom_range(13, 300));
		end
		return cnt_t'($urandom_range(1, 12));
	endfunction

	// mostly clean ticks, some noise with dust or both sides blocked
	function automatic crnav_pkg::sens_t pick_tick(int front_pct);
		crnav_pkg::sens_t s;
		int side;
		if ($urandom_range(0, 99) < 8) begin
			return crnav_pkg::sens_t'(4'($urandom));
		end
		s = '0;
		s.front_blocked = ($urandom_range(0, 99) < front_pct);
		side = $urandom_range(0, 2);
		s.left_blocked = (side == 1);
		s.right_blocked = (side == 2);
		return s;
	endfunction

	task automatic report_mismatch(string what, cnt_t got, cnt_t want);
		n_bad++;
		$display("%0t mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	task automatic check_result();
		crnav_pkg::res_t want;
		if (due_moves.size() == 0) begin
			report_mismatch("result beat with nothing due", '0, '0);
			return;
		end
		want = due_moves.pop_front();
		if (res.vacuum_on !== want.vacuum_on) begin
			report_mismatch("vacuum_on", cnt_t'(res.vacuum_on), cnt_t'(want.vacuum_on));
		end
		if (res.move_cmd !== want.move_cmd) begin
			report_mismatch("move_cmd", cnt_t'(res.move_cmd), cnt_t'(want.move_cmd));
		end
		if (res.spiral_amount !== want.spiral_amount) begin
			report_mismatch("spiral_amount", res.spiral_amount, want.spiral_amount);
		end
		if (res.mode_now !== want.mode_now) begin
			report_mismatch("mode_now", cnt_t'(res.mode_now), cnt_t'(want.mode_now));
		end
	endtask

	// result side: check every beat, random stalls and long holds
	always @(posedge clk) begin
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			check_result();
		end
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_tick(crnav_pkg::sens_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sens.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sens.valid <= 1'b1;
		sens.front_blocked <= s.front_blocked;
		sens.left_blocked <= s.left_blocked;
		sens.right_blocked <= s.right_blocked;
		sens.dust_full <= s.dust_full;
		@(posedge clk);
		while (sens.ready !== 1'b1) @(posedge clk);
		due_moves.push_back(nav_step(s));
	endtask

	task automatic settle();
		sens.valid <= 1'b0;
		@(posedge clk);
		while (due_moves.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_limits(crnav_pkg::limits_t l);
		cnt_t vals [4];
		logic [crnav_pkg::CFG_IDX_W-1:0] regs [4];
		settle();
		vals = '{l.linear_limit, l.circle_limit, l.edge_limit, l.edge_clear_limit};
		regs = '{crnav_pkg::REG_LINEAR_LIMIT, crnav_pkg::REG_CIRCLE_LIMIT,
			crnav_pkg::REG_EDGE_LIMIT, crnav_pkg::REG_EDGE_CLEAR_LIMIT};
		cfg.valid <= 1'b1;
		for (int k = 0; k < 4; k++) begin
			cfg.index <= regs[k];
			cfg.data <= vals[k];
			@(posedge clk);
			while (cfg.ready !== 1'b1) @(posedge clk);
		end
		cfg.valid <= 1'b0;
		lim = l;
	endtask

	// reset limits: linear timeout, then edge clear timeout
	task automatic test_reset_limits();
		crnav_pkg::sens_t s;
		for (int i = 0; i < 1250; i++) begin
			s = '0;
			s.front_blocked = (i < 1000 && i % 150 == 149) || i == 1010;
			send_tick(s);
		end
	endtask

	// every flag combination, then a walk through all modes and all commands but FWD_RIGHT_SLOW
	task automatic test_mode_walk();
		crnav_pkg::sens_t fwd;
		fwd = '0;
		fwd.front_blocked = 1'b1;
		apply_limits(crnav_pkg::limits_t'{16'd0, 16'd2, 16'd9, 16'd7});
		for (int k = 0; k < 16; k++) begin
			send_tick(crnav_pkg::sens_t'(4'(k)));
		end
		repeat (2) send_tick('0);
		send_tick(fwd);
		repeat (6) send_tick('0);
		send_tick(fwd);
		repeat (3) send_tick('0);
	endtask

	task automatic test_zero_limits();
		apply_limits(crnav_pkg::limits_t'{16'd0, 16'd0, 16'd0, 16'd0});
		repeat (150) send_tick(pick_tick(30));
	endtask

	task automatic test_random_traffic();
		crnav_pkg::limits_t l;
		int front_pct;
		for (int ph = 0; ph < 8; ph++) begin
			l.linear_limit = pick_limit();
			l.circle_limit = pick_limit();
			l.edge_limit = pick_limit();
			l.edge_clear_limit = pick_limit();
			apply_limits(l);
			idle_on = (ph % 3 != 1);
			front_pct = $urandom_range(2, 40);
			repeat (50) send_tick(pick_tick(front_pct));
		end
		idle_on = 1'b1;
	endtask

	// receiver holds off while ticks keep coming
	task automatic test_backpressure();
		apply_limits(crnav_pkg::limits_t'{16'd4, 16'd6, 16'd20, 16'd5});
		settle();
		idle_on = 1'b0;
		hold_left = 200;
		repeat (60) send_tick(pick_tick(20));
		idle_on = 1'b1;
	endtask

	// limits at the top never time out
	task automatic test_max_limits();
		apply_limits(crnav_pkg::limits_t'{crnav_pkg::CNT_MAX, crnav_pkg::CNT_MAX,
			crnav_pkg::CNT_MAX, crnav_pkg::CNT_MAX});
		idle_on = 1'b0;
		repeat (40) send_tick(pick_tick(20));
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		sens.valid <= 1'b0;
		sens.front_blocked <= 1'b0;
		sens.left_blocked <= 1'b0;
		sens.right_blocked <= 1'b0;
		sens.dust_full <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= crnav_pkg::REG_LINEAR_LIMIT;
		cfg.data <= '0;
		lim = '{crnav_pkg::LINEAR_LIMIT_RST, crnav_pkg::CIRCLE_LIMIT_RST,
			crnav_pkg::EDGE_LIMIT_RST, crnav_pkg::EDGE_CLEAR_LIMIT_RST};
		restart_mode(crnav_pkg::MODE_LINEAR);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_limits();
		test_mode_walk();
		test_zero_limits();
		test_random_traffic();
		test_backpressure();
		test_max_limits();
		settle();
		repeat (4) @(posedge clk);
		if (n_bad == 0) begin
			$display("[cleaning_robot_navigation_fsm_top] OK");
		end else begin
			$display("[cleaning_robot_navigation_fsm_top] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[cleaning_robot_navigation_fsm_top] ERROR");
		$finish;
	end

endmodule
